/* rtl/isometric_box_overlap_order_unit_assert.svh */
// Assertion macros used by the order unit design file.
`ifndef ISOMETRIC_BOX_OVERLAP_ORDER_UNIT_ASSERT_SVH
`define ISOMETRIC_BOX_OVERLAP_ORDER_UNIT_ASSERT_SVH

// Implication checked at every rising clock edge outside reset.
`define IBOO_ASSERT_IMPL(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define IBOO_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("assertion failed");

`endif

/* rtl/iboo_pkg.sv */
package iboo_pkg;

   // Internal flag bit positions of a prepared box.
   localparam int FL_TRANS_BIT = 0;
   localparam int FL_ANIM_BIT  = 1;
   localparam int FL_SOLID_BIT = 2;
   localparam int FL_DRAW_BIT  = 3;
   localparam int FL_FLAT_BIT  = 4;

   localparam logic ACT_CLEAR = 1'b0;
   localparam logic ACT_ADD   = 1'b1;

   localparam int ID_BITS    = 16;
   localparam int FLAG_BITS  = 4;
   localparam int IDX_BITS   = 6;
   localparam int COORD_BITS = 16;

   // Comparison outcome of one cell for the box it holds.
   typedef struct packed {
      logic paired;
      logic overlaps;
      logic stored_behind;
   } cmp_result_type;

endpackage

/* rtl/iboo_cell.sv */
// One store slot. It holds one box, and when an add passes by it compares
// the broadcast new box with its own box.
module iboo_cell #(
   parameter int COORD_BITS = 16
) (
   input  logic                      clock,
   input  logic                      write_en,
   input  logic [COORD_BITS-1:0]     w_xr, w_yn, w_zb, w_xl, w_yf, w_zt,
   input  logic [iboo_pkg::ID_BITS-1:0]   w_id,
   input  logic [iboo_pkg::FLAG_BITS-1:0] w_flags,
   input  logic [COORD_BITS-1:0]     n_xr, n_yn, n_zb, n_xl, n_yf, n_zt,
   input  logic [iboo_pkg::ID_BITS-1:0]   n_id,
   input  logic [iboo_pkg::FLAG_BITS-1:0] n_flags,
   output iboo_pkg::cmp_result_type  result
);
   localparam int W = COORD_BITS + 4;

   logic [COORD_BITS-1:0] xr_ff, yn_ff, zb_ff, xl_ff, yf_ff, zt_ff;
   logic [iboo_pkg::ID_BITS-1:0]   id_ff;
   logic [iboo_pkg::FLAG_BITS-1:0] fl_ff;

   always_ff @(posedge clock) begin
      if (write_en) begin
         xr_ff <= w_xr; yn_ff <= w_yn; zb_ff <= w_zb;
         xl_ff <= w_xl; yf_ff <= w_yf; zt_ff <= w_zt;
         id_ff <= w_id; fl_ff <= w_flags;
      end
   end

   typedef logic signed [W-1:0] sw_type;

   function automatic sw_type q4(input logic [COORD_BITS-1:0] v);
      return sw_type'({4'b0, v} >> 2);
   endfunction
   function automatic sw_type q8(input logic [COORD_BITS-1:0] v);
      return sw_type'({4'b0, v} >> 3);
   endfunction
   function automatic sw_type ext(input logic [COORD_BITS-1:0] v);
      return sw_type'({4'b0, v});
   endfunction
   function automatic logic [COORD_BITS-1:0] mid(input logic [COORD_BITS-1:0] a,
                                                  input logic [COORD_BITS-1:0] b);
      logic [COORD_BITS:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[COORD_BITS:1];
   endfunction

   // a = stored box, b = new box
   sw_type a_sxl, a_sxr, a_sxt, a_syt, a_sxb, a_syb;
   sw_type b_sxl, b_sxr, b_sxt, b_syt, b_sxb, b_syb;
   sw_type t0, t1, u0, u1;
   logic   meet;
   logic   beh;
   logic [4:0] fa, fb;
   logic [COORD_BITS:0] sa1, sb1, sa2, sb2;

   always_comb begin
      a_sxl = q4(xl_ff) - q4(yn_ff);  a_sxr = q4(xr_ff) - q4(yf_ff);
      a_sxt = q4(xl_ff) - q4(yf_ff);  a_syt = q8(xl_ff) + q8(yf_ff) - ext(zt_ff);
      a_sxb = q4(xr_ff) - q4(yn_ff);  a_syb = q8(xr_ff) + q8(yn_ff) - ext(zb_ff);
      b_sxl = q4(n_xl) - q4(n_yn);    b_sxr = q4(n_xr) - q4(n_yf);
      b_sxt = q4(n_xl) - q4(n_yf);    b_syt = q8(n_xl) + q8(n_yf) - ext(n_zt);
      b_sxb = q4(n_xr) - q4(n_yn);    b_syb = q8(n_xr) + q8(n_yn) - ext(n_zb);
      t0 = a_sxt - b_sxb;  t1 = a_syt - b_syb;
      u0 = a_sxb - b_sxt;  u1 = a_syb - b_syt;
      meet = !(a_sxr <= b_sxl) && !(a_sxl >= b_sxr)
          && !(t0 + (t1 <<< 1) >= 0) && !(-t0 + (t1 <<< 1) >= 0)
          && !(u0 - (u1 <<< 1) >= 0) && !(-u0 - (u1 <<< 1) >= 0);

      fa = {zt_ff == zb_ff, fl_ff[3], fl_ff[2:0]};
      fb = {n_zt == n_zb, n_flags[3], n_flags[2:0]};
      sa1 = {1'b0, xr_ff} + {1'b0, yn_ff};  sb1 = {1'b0, n_xr} + {1'b0, n_yn};
      sa2 = {1'b0, xl_ff} + {1'b0, yf_ff};  sb2 = {1'b0, n_xl} + {1'b0, n_yf};

      if (fa[iboo_pkg::FL_FLAT_BIT] && fb[iboo_pkg::FL_FLAT_BIT]
          && (zt_ff != n_zt))                                  beh = zt_ff < n_zt;
      else if (fa[iboo_pkg::FL_FLAT_BIT] && fb[iboo_pkg::FL_FLAT_BIT]
          && fa[iboo_pkg::FL_ANIM_BIT] != fb[iboo_pkg::FL_ANIM_BIT])
         beh = fb[iboo_pkg::FL_ANIM_BIT];
      else if (fa[iboo_pkg::FL_FLAT_BIT] && fb[iboo_pkg::FL_FLAT_BIT]
          && fa[iboo_pkg::FL_TRANS_BIT] != fb[iboo_pkg::FL_TRANS_BIT])
         beh = fb[iboo_pkg::FL_TRANS_BIT];
      else if (fa[iboo_pkg::FL_FLAT_BIT] && fb[iboo_pkg::FL_FLAT_BIT]
          && fa[iboo_pkg::FL_DRAW_BIT] != fb[iboo_pkg::FL_DRAW_BIT])
         beh = fa[iboo_pkg::FL_DRAW_BIT];
      else if (fa[iboo_pkg::FL_FLAT_BIT] && fb[iboo_pkg::FL_FLAT_BIT]
          && fa[iboo_pkg::FL_SOLID_BIT] != fb[iboo_pkg::FL_SOLID_BIT])
         beh = fa[iboo_pkg::FL_SOLID_BIT];
      else if (!(fa[iboo_pkg::FL_FLAT_BIT] && fb[iboo_pkg::FL_FLAT_BIT])
          && zt_ff <= n_zb)                                    beh = 1'b1;
      else if (!(fa[iboo_pkg::FL_FLAT_BIT] && fb[iboo_pkg::FL_FLAT_BIT])
          && zb_ff >= n_zt)                                    beh = 1'b0;
      else if (xr_ff <= n_xl)                                  beh = 1'b1;
      else if (xl_ff >= n_xr)                                  beh = 1'b0;
      else if (yn_ff <= n_yf)                                  beh = 1'b1;
      else if (yf_ff >= n_yn)                                  beh = 1'b0;
      else if (zb_ff < n_zb)                                   beh = 1'b1;
      else if (zb_ff > n_zb)                                   beh = 1'b0;
      else if (mid(zt_ff, zb_ff) <= n_zb)                      beh = 1'b1;
      else if (zb_ff >= mid(n_zt, n_zb))                       beh = 1'b0;
      else if (mid(xr_ff, xl_ff) <= n_xl)                      beh = 1'b1;
      else if (xl_ff >= mid(n_xr, n_xl))                       beh = 1'b0;
      else if (mid(yn_ff, yf_ff) <= n_yf)                      beh = 1'b1;
      else if (yf_ff >= mid(n_yn, n_yf))                       beh = 1'b0;
      else if (sa1 != sb1)                                     beh = sa1 < sb1;
      else if (sa2 != sb2)                                     beh = sa2 < sb2;
      else if (xr_ff != n_xr)                                  beh = xr_ff < n_xr;
      else if (yn_ff != n_yn)                                  beh = yn_ff < n_yn;
      else                                                     beh = id_ff < n_id;

      result.paired        = 1'b1;
      result.overlaps      = meet;
      result.stored_behind = meet && beh;
   end
endmodule

/* rtl/isometric_box_overlap_order_unit.sv */
// Channel | Direction | Handshake           | Payload
// req_    | in        | req_valid/req_stall | action, box id, flags, six coordinates
// rsp_    | out       | rsp_valid/rsp_stall | index, paired, overlaps, behind, accepted, last
//
// Each stored box sits in a cell of a row. An add holds the new box in a
// broadcast register and walks a scan pointer along the row, one cell per
// cycle while the receiver does not stall, so an add with N stored boxes
// presents N results (one for an empty store), each from an output register.
// A clear empties the store without a scan. Reset is synchronous and empties
// the store. A stalled result holds the scan; the next item is accepted once
// the last result has been taken.
module isometric_box_overlap_order_unit #(
   parameter int CAPACITY   = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_action,
   input  logic [15:0]               req_box_id,
   input  logic [3:0]                req_render_flags,
   input  logic [15:0]               req_x_right,
   input  logic [15:0]               req_y_near,
   input  logic [15:0]               req_z_bottom,
   input  logic [15:0]               req_x_left,
   input  logic [15:0]               req_y_far,
   input  logic [15:0]               req_z_top,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [5:0]                rsp_other_index,
   output logic                      rsp_paired,
   output logic                      rsp_overlaps,
   output logic                      rsp_stored_behind,
   output logic                      rsp_accepted,
   output logic                      rsp_last
);
   localparam int COORD_BITS = iboo_pkg::COORD_BITS;
   localparam int IW = $clog2(CAPACITY + 1);
   localparam int SW = $clog2(CAPACITY);

   // The new box being compared, held for the whole scan.
   logic [COORD_BITS-1:0] n_xr_ff, n_yn_ff, n_zb_ff, n_xl_ff, n_yf_ff, n_zt_ff;
   logic [15:0] n_id_ff;
   logic [3:0]  n_fl_ff;

   logic          busy_ff, busy_in;
   logic [IW-1:0] count_ff, count_in;
   logic [IW-1:0] scan_ff, scan_in;
   logic          acc_ff, acc_in;
   logic          out_valid_ff, out_valid_in;
   logic [5:0]    out_idx_ff;
   iboo_pkg::cmp_result_type out_res_ff, sel_res;
   logic          out_acc_ff, out_last_ff;

   iboo_pkg::cmp_result_type cell_res [CAPACITY];
   logic [CAPACITY-1:0] wr_en;

   logic req_fire, rsp_fire, emit, issue_last;

   assign req_stall = busy_ff || out_valid_ff;
   assign req_fire  = req_valid && !req_stall;
   assign rsp_fire  = out_valid_ff && !rsp_stall;
   assign emit      = busy_ff && (!out_valid_ff || !rsp_stall);
   assign issue_last = (count_ff == '0) || (scan_ff + IW'(1) >= count_ff);

   // Write port: the new box goes into the slot after the last stored one
   // when the final result of an accepted add leaves the scan.
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         wr_en[i] = emit && issue_last && acc_ff && (count_ff == IW'(i));
      end
   end

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      iboo_cell #(.COORD_BITS(COORD_BITS)) u_cell (
         .clock   (clock),
         .write_en(wr_en[g]),
         .w_xr(n_xr_ff), .w_yn(n_yn_ff), .w_zb(n_zb_ff),
         .w_xl(n_xl_ff), .w_yf(n_yf_ff), .w_zt(n_zt_ff),
         .w_id(n_id_ff), .w_flags(n_fl_ff),
         .n_xr(n_xr_ff), .n_yn(n_yn_ff), .n_zb(n_zb_ff),
         .n_xl(n_xl_ff), .n_yf(n_yf_ff), .n_zt(n_zt_ff),
         .n_id(n_id_ff), .n_flags(n_fl_ff),
         .result  (cell_res[g])
      );
   end

   always_comb begin
      if (count_ff == '0) sel_res = '0;
      else                sel_res = cell_res[scan_ff[SW-1:0]];
   end

   always_comb begin
      busy_in      = busy_ff;
      count_in     = count_ff;
      scan_in      = scan_ff;
      acc_in       = acc_ff;
      out_valid_in = out_valid_ff;
      if (rsp_fire) out_valid_in = 1'b0;
      if (emit) begin
         out_valid_in = 1'b1;
         scan_in = scan_ff + IW'(1);
         if (issue_last) begin
            busy_in = 1'b0;
            if (acc_ff) count_in = count_ff + IW'(1);
         end
      end
      if (req_fire) begin
         if (req_action == iboo_pkg::ACT_CLEAR) begin
            count_in = '0;
         end else begin
            busy_in = 1'b1;
            scan_in = '0;
            acc_in  = (count_ff < IW'(CAPACITY));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         count_ff     <= '0;
         scan_ff      <= '0;
         acc_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         count_ff     <= count_in;
         scan_ff      <= scan_in;
         acc_ff       <= acc_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         n_xr_ff <= req_x_right[COORD_BITS-1:0];
         n_yn_ff <= req_y_near[COORD_BITS-1:0];
         n_zb_ff <= req_z_bottom[COORD_BITS-1:0];
         n_xl_ff <= req_x_left[COORD_BITS-1:0];
         n_yf_ff <= req_y_far[COORD_BITS-1:0];
         n_zt_ff <= req_z_top[COORD_BITS-1:0];
         n_id_ff <= req_box_id;
         n_fl_ff <= req_render_flags;
      end
      if (emit) begin
         out_idx_ff  <= 6'(scan_ff);
         out_res_ff  <= sel_res;
         out_acc_ff  <= acc_ff;
         out_last_ff <= issue_last;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_other_index   = out_idx_ff;
   assign rsp_paired        = out_res_ff.paired;
   assign rsp_overlaps      = out_res_ff.overlaps;
   assign rsp_stored_behind = out_res_ff.stored_behind;
   assign rsp_accepted      = out_acc_ff;
   assign rsp_last          = out_last_ff;

`include "isometric_box_overlap_order_unit_assert.svh"

   // A stored box never counts past the row length.
   `IBOO_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, count_ff <= IW'(CAPACITY))
   // No new item is taken while a scan is running.
   `IBOO_ASSERT_IMPL(a_no_overlap, clock, reset, busy_ff, req_stall)
   // A result that says "behind" must also report an overlap.
   `IBOO_ASSERT_IMPL(a_behind_needs_overlap, clock, reset,
                     rsp_valid && rsp_stored_behind, rsp_overlaps)
   // After the last result of a scan the unit is no longer busy.
   `IBOO_ASSERT_NEXT(a_last_ends, clock, reset, emit && issue_last, !busy_ff)
endmodule

/* tb/sv/isometric_box_overlap_order_checker.sv */
module isometric_box_overlap_order_checker #(
   parameter int CAPACITY = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic        req_action,
   input  logic [15:0] req_box_id,
   input  logic [3:0]  req_render_flags,
   input  logic [15:0] req_x_right,
   input  logic [15:0] req_y_near,
   input  logic [15:0] req_z_bottom,
   input  logic [15:0] req_x_left,
   input  logic [15:0] req_y_far,
   input  logic [15:0] req_z_top,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [5:0]  rsp_other_index,
   input  logic        rsp_paired,
   input  logic        rsp_overlaps,
   input  logic        rsp_stored_behind,
   input  logic        rsp_accepted,
   input  logic        rsp_last,
   output int          fail_count,
   output int          pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      longint xr, yn, zb, xl, yf, zt;
      longint sxl, sxr, sxt, syt, sxb, syb;
      logic [4:0] fl;
      int unsigned id;
   } iso_box_type;

   typedef struct packed {
      logic [5:0] idx;
      logic paired, overlaps, behind, accepted, last;
   } order_result_type;

   iso_box_type      kept_boxes[CAPACITY];
   int               kept_count;
   order_result_type awaited_results[$];

   assign pending_count = awaited_results.size();

   function automatic iso_box_type project_box(input logic [15:0] xr, yn, zb, xl, yf, zt,
                                               input logic [15:0] id, input logic [3:0] rf);
      iso_box_type b;
      b.xr = xr; b.yn = yn; b.zb = zb; b.xl = xl; b.yf = yf; b.zt = zt;
      b.id = id;
      b.fl = {zt == zb, rf[3], rf[2], rf[1], rf[0]};
      b.sxl = b.xl / 4 - b.yn / 4;
      b.sxr = b.xr / 4 - b.yf / 4;
      b.sxt = b.xl / 4 - b.yf / 4;
      b.syt = b.xl / 8 + b.yf / 8 - b.zt;
      b.sxb = b.xr / 4 - b.yn / 4;
      b.syb = b.xr / 8 + b.yn / 8 - b.zb;
      return b;
   endfunction

   function automatic bit outlines_touch(input iso_box_type a, input iso_box_type b);
      longint t0, t1, u0, u1;
      if (a.sxr <= b.sxl || a.sxl >= b.sxr) return 0;
      t0 = a.sxt - b.sxb;
      t1 = a.syt - b.syb;
      if (t0 + t1 * 2 >= 0 || -t0 + t1 * 2 >= 0) return 0;
      u0 = a.sxb - b.sxt;
      u1 = a.syb - b.syt;
      if (u0 - u1 * 2 >= 0 || -u0 - u1 * 2 >= 0) return 0;
      return 1;
   endfunction

   // True when box a has to be painted before box b.
   function automatic bit paints_first(input iso_box_type a, input iso_box_type b);
      if (a.fl[iboo_pkg::FL_FLAT_BIT] && b.fl[iboo_pkg::FL_FLAT_BIT]) begin
         if (a.zt != b.zt) return a.zt < b.zt;
         if (a.fl[iboo_pkg::FL_ANIM_BIT] != b.fl[iboo_pkg::FL_ANIM_BIT])
            return b.fl[iboo_pkg::FL_ANIM_BIT];
         if (a.fl[iboo_pkg::FL_TRANS_BIT] != b.fl[iboo_pkg::FL_TRANS_BIT])
            return b.fl[iboo_pkg::FL_TRANS_BIT];
         if (a.fl[iboo_pkg::FL_DRAW_BIT] != b.fl[iboo_pkg::FL_DRAW_BIT])
            return a.fl[iboo_pkg::FL_DRAW_BIT];
         if (a.fl[iboo_pkg::FL_SOLID_BIT] != b.fl[iboo_pkg::FL_SOLID_BIT])
            return a.fl[iboo_pkg::FL_SOLID_BIT];
      end else begin
         if (a.zt <= b.zb) return 1;
         if (a.zb >= b.zt) return 0;
      end
      if (a.xr <= b.xl) return 1;
      if (a.xl >= b.xr) return 0;
      if (a.yn <= b.yf) return 1;
      if (a.yf >= b.yn) return 0;
      if (a.zb < b.zb) return 1;
      if (a.zb > b.zb) return 0;
      if ((a.zt + a.zb) / 2 <= b.zb) return 1;
      if (a.zb >= (b.zt + b.zb) / 2) return 0;
      if ((a.xr + a.xl) / 2 <= b.xl) return 1;
      if (a.xl >= (b.xr + b.xl) / 2) return 0;
      if ((a.yn + a.yf) / 2 <= b.yf) return 1;
      if (a.yf >= (b.yn + b.yf) / 2) return 0;
      if (a.xr + a.yn != b.xr + b.yn) return a.xr + a.yn < b.xr + b.yn;
      if (a.xl + a.yf != b.xl + b.yf) return a.xl + a.yf < b.xl + b.yf;
      if (a.xr != b.xr) return a.xr < b.xr;
      if (a.yn != b.yn) return a.yn < b.yn;
      return a.id < b.id;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   always @(posedge clock) begin
      iso_box_type      nb;
      order_result_type r, w;
      bit               acc;
      if (reset) begin
         kept_count = 0;
         fail_count = 0;
         awaited_results.delete();
      end else begin
         if (req_valid && !req_stall) begin
            if (req_action == iboo_pkg::ACT_CLEAR) begin
               kept_count = 0;
            end else begin
               nb = project_box(req_x_right, req_y_near, req_z_bottom, req_x_left,
                                req_y_far, req_z_top, req_box_id, req_render_flags);
               acc = kept_count < CAPACITY;
               if (kept_count == 0) begin
                  awaited_results.push_back('{6'd0, 1'b0, 1'b0, 1'b0, acc, 1'b1});
               end
               for (int i = 0; i < kept_count; i++) begin
                  r.idx = 6'(i);
                  r.paired = 1'b1;
                  r.overlaps = outlines_touch(kept_boxes[i], nb);
                  r.behind = r.overlaps && paints_first(kept_boxes[i], nb);
                  r.accepted = acc;
                  r.last = (i == kept_count - 1);
                  awaited_results.push_back(r);
               end
               if (acc) begin
                  kept_boxes[kept_count] = nb;
                  kept_count = kept_count + 1;
               end
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (awaited_results.size() == 0) begin
               report_mismatch("unexpected result, index", rsp_other_index, -1);
            end else begin
               w = awaited_results.pop_front();
               if (rsp_other_index !== w.idx)
                  report_mismatch("other_index", rsp_other_index, w.idx);
               if (rsp_paired !== w.paired) report_mismatch("paired", rsp_paired, w.paired);
               if (rsp_overlaps !== w.overlaps)
                  report_mismatch("overlaps", rsp_overlaps, w.overlaps);
               if (rsp_stored_behind !== w.behind)
                  report_mismatch("stored_behind", rsp_stored_behind, w.behind);
               if (rsp_accepted !== w.accepted)
                  report_mismatch("accepted", rsp_accepted, w.accepted);
               if (rsp_last !== w.last) report_mismatch("last", rsp_last, w.last);
            end
         end
      end
   end
endmodule

/* tb/sv/tb_isometric_box_overlap_order_unit.sv */
module tb_isometric_box_overlap_order_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAPACITY = 32;
   // Cycles without any accepted item before the run is declared hung.
   localparam int IDLE_LIMIT = 5000;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic        req_action = iboo_pkg::ACT_CLEAR;
   logic [15:0] req_box_id = '0;
   logic [3:0]  req_render_flags = '0;
   logic [15:0] req_x_right = '0, req_y_near = '0, req_z_bottom = '0;
   logic [15:0] req_x_left = '0, req_y_far = '0, req_z_top = '0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [5:0]  rsp_other_index;
   logic        rsp_paired, rsp_overlaps, rsp_stored_behind, rsp_accepted, rsp_last;
   int          fail_count, pending_count;
   int          idle_cycles = 0;

   isometric_box_overlap_order_unit #(.CAPACITY(CAPACITY)) i_dut (.*);
   isometric_box_overlap_order_checker #(.CAPACITY(CAPACITY)) i_checker (.*);

   initial begin
      forever #10 clock = ~clock;
   end

   // Gap lengths: mostly zero or short, now and then a long one.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // The receiver stalls in bursts; some stretches never stall at all.
   initial begin
      int n;
      forever begin
         @(negedge clock);
         n = pick_gap();
         if (n > 0 && $urandom_range(0, 3) != 0) begin
            rsp_stall <= 1;
            repeat (n) @(negedge clock);
            rsp_stall <= 0;
         end else begin
            repeat ($urandom_range(1, 12)) @(negedge clock);
         end
      end
   end

   // Watchdog on accepted items of either channel.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (!reset) begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   // Hands one item over and holds it until the handshake completes.
   task automatic send_item(input logic act, input logic [15:0] id, input logic [3:0] rf,
                            input logic [15:0] xr, yn, zb, xl, yf, zt);
      req_valid <= 1;
      req_action <= act;
      req_box_id <= id;
      req_render_flags <= rf;
      req_x_right <= xr;
      req_y_near <= yn;
      req_z_bottom <= zb;
      req_x_left <= xl;
      req_y_far <= yf;
      req_z_top <= zt;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic pause_sender();
      int n;
      n = pick_gap();
      if (n > 0) begin
         req_valid <= 0;
         repeat (n) @(negedge clock);
      end
   endtask

   // A box near the origin so that outlines often meet; wide extents on request.
   task automatic send_random_box(input bit spread);
      logic [15:0] xl, yf, zb, w, d, h;
      int span;
      span = spread ? 65535 : 300;
      xl = 16'($urandom_range(0, span));
      yf = 16'($urandom_range(0, span));
      zb = 16'($urandom_range(0, span));
      w = 16'($urandom_range(0, spread ? 65535 : 200));
      d = 16'($urandom_range(0, spread ? 65535 : 200));
      h = ($urandom_range(0, 4) == 0) ? 16'd0
                                      : 16'($urandom_range(0, spread ? 65535 : 200));
      send_item(iboo_pkg::ACT_ADD, 16'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                16'(xl + w), 16'(yf + d), zb, xl, yf, 16'(zb + h));
   endtask

   task automatic wait_drained();
      req_valid <= 0;
      while (pending_count != 0) @(negedge clock);
   endtask

   initial begin
      int count;
      repeat (9) @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // Directed items: add to the empty store, extremes, flat boxes, ties.
      send_item(iboo_pkg::ACT_ADD, 16'h0000, 4'h0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
      send_item(iboo_pkg::ACT_ADD, 16'hffff, 4'hf, 16'hffff, 16'hffff, 16'hffff,
                16'hffff, 16'hffff, 16'hffff);
      send_item(iboo_pkg::ACT_ADD, 16'h0001, 4'h5, 16'd100, 16'd100, 16'd0,
                16'd0, 16'd0, 16'd50);
      send_item(iboo_pkg::ACT_ADD, 16'h0002, 4'ha, 16'd120, 16'd110, 16'd10,
                16'd20, 16'd10, 16'd60);
      send_item(iboo_pkg::ACT_ADD, 16'h0003, 4'h1, 16'd100, 16'd100, 16'd0,
                16'd0, 16'd0, 16'd0);
      send_item(iboo_pkg::ACT_ADD, 16'h0004, 4'h2, 16'd100, 16'd100, 16'd0,
                16'd0, 16'd0, 16'd0);
      send_item(iboo_pkg::ACT_ADD, 16'h0005, 4'h8, 16'd100, 16'd100, 16'd0,
                16'd0, 16'd0, 16'd0);
      send_item(iboo_pkg::ACT_ADD, 16'h0006, 4'h4, 16'd100, 16'd100, 16'd0,
                16'd0, 16'd0, 16'd0);
      send_item(iboo_pkg::ACT_ADD, 16'h0001, 4'h5, 16'd100, 16'd100, 16'd0,
                16'd0, 16'd0, 16'd50);
      send_item(iboo_pkg::ACT_ADD, 16'h0000, 4'h5, 16'd100, 16'd100, 16'd0,
                16'd0, 16'd0, 16'd50);
      send_item(iboo_pkg::ACT_ADD, 16'h0007, 4'h0, 16'haaaa, 16'h5555, 16'h5555,
                16'h5555, 16'haaaa, 16'haaaa);
      send_item(iboo_pkg::ACT_CLEAR, 16'hffff, 4'hf, 16'hffff, 16'hffff, 16'hffff,
                16'hffff, 16'hffff, 16'hffff);
      send_item(iboo_pkg::ACT_ADD, 16'h0008, 4'h3, 16'd50, 16'd50, 16'd5,
                16'd10, 16'd10, 16'd5);

      // Sender waits here until every result is back.
      wait_drained();

      // Fill the store past capacity to reach the full case.
      send_item(iboo_pkg::ACT_CLEAR, 16'd0, 4'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
      for (int i = 0; i < CAPACITY + 3; i++) begin
         send_random_box(0);
         pause_sender();
      end

      // Random part: well-formed boxes, occasional clears and wild extents.
      count = 0;
      while (count < 150) begin
         if ($urandom_range(0, 24) == 0)
            send_item(iboo_pkg::ACT_CLEAR, 16'($urandom), 4'($urandom), 16'($urandom),
                      16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom));
         else if ($urandom_range(0, 9) == 0)
            send_item(iboo_pkg::ACT_ADD, 16'($urandom), 4'($urandom), 16'($urandom),
                      16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom));
         else
            send_random_box($urandom_range(0, 7) == 0);
         count++;
         pause_sender();
      end

      wait_drained();
      repeat (2 * CAPACITY + 10) @(negedge clock);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule

/* filelist.f */
+incdir+rtl
rtl/iboo_pkg.sv
rtl/iboo_cell.sv
rtl/isometric_box_overlap_order_unit.sv
tb/sv/isometric_box_overlap_order_checker.sv
tb/sv/tb_isometric_box_overlap_order_unit.sv
